/* rtl/core/pnce_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pnce_pkg;

  localparam int MAX_GRID_SCALE = 64;
  localparam int POS_BITS       = 24;

  localparam int FIELD_W   = 24;
  localparam int EDGE_W    = 24;
  localparam int GS_W      = 7;
  localparam int HASH_W    = 18;
  localparam int NBR_W     = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 24;

  localparam int SCALE_W = $clog2(MAX_GRID_SCALE + 1);
  localparam int IDX_W   = (MAX_GRID_SCALE > 1) ? $clog2(MAX_GRID_SCALE) : 1;
  localparam int STEP_W  = (IDX_W > 1) ? $clog2(IDX_W) : 1;
  localparam int LIM_W   = SCALE_W + EDGE_W;
  localparam int DIV_W   = FIELD_W + IDX_W;
  localparam int SS_W    = 2 * SCALE_W;

  localparam logic [FIELD_W-1:0] POS_MASK =
    FIELD_W'((64'(1) << POS_BITS) - 64'(1));

  localparam logic [EDGE_W-1:0] EDGE_RESET = EDGE_W'(256);
  localparam logic [GS_W-1:0]   GS_RESET   = GS_W'(16);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [NBR_W-1:0] NBR_LAST = NBR_W'(26);
  localparam logic [1:0]       OFF_MAX  = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CELL_EDGE  = 1'b0,
    CFG_GRID_SCALE = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [FIELD_W-1:0] pos_x;
    logic [FIELD_W-1:0] pos_y;
    logic [FIELD_W-1:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic [HASH_W-1:0] cell_hash;
    logic [NBR_W-1:0]  neighbor_number;
    logic              last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] hx;
    logic [IDX_W-1:0] hy;
    logic [IDX_W-1:0] hz;
  } home_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

`default_nettype wire

/* rtl/core/pnce_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module pnce_front (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  pnce_pkg::in_item_t           in_data_i,
  input  wire [pnce_pkg::EDGE_W-1:0]   edge_i,
  input  wire [pnce_pkg::SCALE_W-1:0]  scale_i,
  input  wire [pnce_pkg::LIM_W-1:0]    lim_i,
  input  pnce_pkg::queue_stat_t        qstat_i,
  output logic                         push_o,
  output pnce_pkg::home_t              home_o
);
  import pnce_pkg::*;

  logic                busy_q;
  logic [STEP_W-1:0]   step_q;
  logic                first_q;
  logic [FIELD_W-1:0]  rem_q [3];
  logic [FIELD_W-1:0]  rem_d [3];
  logic [IDX_W-1:0]    quo_q [3];
  logic [IDX_W-1:0]    quo_d [3];
  logic                sat_q [3];
  logic                sat_d [3];
  logic [IDX_W-1:0]    idx   [3];
  logic [DIV_W-1:0]    shifted;
  logic                ge;
  logic                last_step;
  logic                hold;
  logic                accept;

  assign last_step  = (step_q == '0);
  assign push_o     = busy_q && last_step && !qstat_i.full;
  assign hold       = busy_q && last_step && qstat_i.full;
  assign in_stall_o = busy_q && !(last_step && !qstat_i.full);
  assign accept     = in_valid_i && !in_stall_o;
  assign shifted    = DIV_W'(edge_i) << step_q;

  // one restoring quotient bit per cycle on each axis
  always_comb begin
    ge = 1'b0;
    for (int a = 0; a < 3; a++) begin
      ge       = (DIV_W'(rem_q[a]) >= shifted);
      sat_d[a] = first_q ? (LIM_W'(rem_q[a]) >= lim_i) : sat_q[a];
      rem_d[a] = ge ? (rem_q[a] - shifted[FIELD_W-1:0]) : rem_q[a];
      quo_d[a] = quo_q[a] | (IDX_W'(ge) << step_q);
      idx[a]   = sat_d[a] ? IDX_W'(scale_i - SCALE_W'(1)) : quo_d[a];
    end
  end

  assign home_o.hx = idx[0];
  assign home_o.hy = idx[1];
  assign home_o.hz = idx[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (accept) begin
      busy_q <= 1'b1;
    end else if (push_o) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rem_q[0] <= in_data_i.pos_x & POS_MASK;
      rem_q[1] <= in_data_i.pos_y & POS_MASK;
      rem_q[2] <= in_data_i.pos_z & POS_MASK;
      for (int a = 0; a < 3; a++) begin
        quo_q[a] <= '0;
        sat_q[a] <= 1'b0;
      end
      step_q  <= STEP_W'(IDX_W - 1);
      first_q <= 1'b1;
    end else if (busy_q && !hold && !last_step) begin
      for (int a = 0; a < 3; a++) begin
        rem_q[a] <= rem_d[a];
        quo_q[a] <= quo_d[a];
        sat_q[a] <= sat_d[a];
      end
      step_q  <= step_q - STEP_W'(1);
      first_q <= 1'b0;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/pnce_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none

module pnce_fifo (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    push_i,
  input  pnce_pkg::home_t        push_data_i,
  input  wire                    pop_i,
  output pnce_pkg::home_t        head_o,
  output pnce_pkg::queue_stat_t  stat_o
);
  import pnce_pkg::*;

  home_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_q;
  logic [QPTR_W-1:0]  rd_q;
  logic [QCNT_W-1:0]  cnt_q;
  logic [QCNT_W-1:0]  cnt_d;

  assign head_o       = mem_q[rd_q];
  assign stat_o.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/pnce_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module pnce_back (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  pnce_pkg::home_t              head_i,
  input  pnce_pkg::queue_stat_t        qstat_i,
  output logic                         pop_o,
  input  wire [pnce_pkg::SCALE_W-1:0]  scale_i,
  input  wire [pnce_pkg::SS_W-1:0]     ss_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output pnce_pkg::out_item_t          out_data_o
);
  import pnce_pkg::*;

  localparam int HSUM_W = SS_W + IDX_W + 2;

  function automatic logic [IDX_W-1:0] wrap_axis(input logic [IDX_W-1:0]   h,
                                                 input logic [1:0]         off,
                                                 input logic [SCALE_W-1:0] s);
    logic [SCALE_W:0] v;
    v = (SCALE_W+1)'(h) + (SCALE_W+1)'(off);
    if (v == '0) begin
      v = (SCALE_W+1)'(s) - (SCALE_W+1)'(1);
    end else begin
      v = v - (SCALE_W+1)'(1);
      if (v >= (SCALE_W+1)'(s)) begin
        v = v - (SCALE_W+1)'(s);
      end
    end
    return v[IDX_W-1:0];
  endfunction

  logic [1:0]        dx_q, dy_q, dz_q;
  logic [NBR_W-1:0]  k_q;
  logic              ov_q;
  out_item_t         out_q;
  logic              adv;
  logic              last;
  logic [IDX_W-1:0]  cx, cy, cz;
  logic [HSUM_W-1:0] hash_sum;

  assign adv  = !qstat_i.empty && (!ov_q || !out_stall_i);
  assign last = (k_q == NBR_LAST);
  assign pop_o = adv && last;

  assign cx = wrap_axis(head_i.hx, dx_q, scale_i);
  assign cy = wrap_axis(head_i.hy, dy_q, scale_i);
  assign cz = wrap_axis(head_i.hz, dz_q, scale_i);
  assign hash_sum = HSUM_W'(cx) + HSUM_W'(scale_i) * HSUM_W'(cy)
                  + HSUM_W'(ss_i) * HSUM_W'(cz);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      dx_q <= '0;
      dy_q <= '0;
      dz_q <= '0;
      k_q  <= '0;
    end else if (adv) begin
      ov_q <= 1'b1;
      if (last) begin
        dx_q <= '0;
        dy_q <= '0;
        dz_q <= '0;
        k_q  <= '0;
      end else begin
        k_q <= k_q + NBR_W'(1);
        if (dz_q != OFF_MAX) begin
          dz_q <= dz_q + 2'd1;
        end else begin
          dz_q <= '0;
          if (dy_q != OFF_MAX) begin
            dy_q <= dy_q + 2'd1;
          end else begin
            dy_q <= '0;
            dx_q <= dx_q + 2'd1;
          end
        end
      end
    end else if (!out_stall_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.cell_hash       <= hash_sum[HASH_W-1:0];
      out_q.neighbor_number <= k_q;
      out_q.last_of_run     <= last;
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

/* rtl/core/periodic_neighbor_cell_enumerator.sv */
`timescale 1ns / 1ps
`default_nettype none

// Periodic 27-cell neighbor enumerator for a cell list.
// Input channel (in_valid_i / in_stall_o / in_data_i) carries one particle
// position per transfer; the output channel (out_valid_o / out_stall_i /
// out_data_o) carries 27 neighbor cell hashes per particle, x offset
// outermost, z innermost, last_of_run set on the twenty-seventh.
// Configuration: cfg_we_i writes cfg_data_i to the register cfg_idx_i
// (0 cell edge, 1 grid scale); write only while the block is idle.
// Datapath: the home cell is found by division, one quotient bit per cycle on all
// three axes, then passes through the queue into the output register.
// Throughput: one hash per cycle while the receiver does not stall, stepped by the
// neighbor counter of the output stage; the front computes the next home
// cell meanwhile and a two-entry queue holds finished home cells.
// Reset: queue, counters and output valid clear; cell edge 1.0, grid 16.
// A stalled receiver holds the output register; the queue then fills and
// the input stalls, with no result lost.
module periodic_neighbor_cell_enumerator (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire [pnce_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire [pnce_pkg::CFG_W-1:0]      cfg_data_i,
  input  wire                            in_valid_i,
  output logic                           in_stall_o,
  input  pnce_pkg::in_item_t             in_data_i,
  output logic                           out_valid_o,
  input  wire                            out_stall_i,
  output pnce_pkg::out_item_t            out_data_o
);
  import pnce_pkg::*;

  logic [EDGE_W-1:0]  edge_q;
  logic [GS_W-1:0]    gs_q;
  logic [SCALE_W-1:0] scale_d, scale_q;
  logic [LIM_W-1:0]   lim_q;
  logic [SS_W-1:0]    ss_q;
  queue_stat_t        qstat;
  home_t              push_home;
  home_t              head;
  logic               push;
  logic               pop;

  always_comb begin
    if (gs_q == '0) begin
      scale_d = SCALE_W'(1);
    end else if (32'(gs_q) > MAX_GRID_SCALE) begin
      scale_d = SCALE_W'(MAX_GRID_SCALE);
    end else begin
      scale_d = SCALE_W'(gs_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_q  <= EDGE_RESET;
      gs_q    <= GS_RESET;
      scale_q <= SCALE_W'(GS_RESET);
      lim_q   <= LIM_W'(GS_RESET) * LIM_W'(EDGE_RESET);
      ss_q    <= SS_W'(GS_RESET) * SS_W'(GS_RESET);
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          CFG_CELL_EDGE:  edge_q <= cfg_data_i[EDGE_W-1:0];
          CFG_GRID_SCALE: gs_q   <= cfg_data_i[GS_W-1:0];
          default: ;
        endcase
      end
      scale_q <= scale_d;
      lim_q   <= LIM_W'(scale_d) * LIM_W'(edge_q);
      ss_q    <= SS_W'(scale_d) * SS_W'(scale_d);
    end
  end

  pnce_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .edge_i     (edge_q),
    .scale_i    (scale_q),
    .lim_i      (lim_q),
    .qstat_i    (qstat),
    .push_o     (push),
    .home_o     (push_home)
  );

  pnce_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_home),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (qstat)
  );

  pnce_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .qstat_i     (qstat),
    .pop_o       (pop),
    .scale_i     (scale_q),
    .ss_i        (ss_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

/* rtl/core/pnce_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module pnce_checker (
  input wire                  clk_i,
  input wire                  rst_ni,
  input wire                  out_valid_o,
  input wire                  out_stall_i,
  input pnce_pkg::out_item_t  out_data_o
);
  import pnce_pkg::*;

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // flag marks the final stencil entry only
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.last_of_run == (out_data_o.neighbor_number == NBR_LAST)))
    else $error("last_of_run mismatch");

  // a run streams without gaps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.last_of_run |=> out_valid_o)
    else $error("gap inside a run");

  // numbers count up within a run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.last_of_run |=>
      out_data_o.neighbor_number == $past(out_data_o.neighbor_number) + NBR_W'(1))
    else $error("neighbor number out of order");

endmodule

bind periodic_neighbor_cell_enumerator pnce_checker u_pnce_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
